FILE: rtl/ppq_pkg.sv
// Shared types and codes for the priority process queue.
package ppq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_RUN_HEAD = 2'd1,
    CMD_RUN_PRIO = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_SCAN = 3'b010,
    FSM_DONE = 3'b100
  } fsm_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     kept;
  } cell_ctrl_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] proc_id;
    logic [7:0]  priority_req;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  removed_count;
    logic [4:0]  occupancy;
    logic [15:0] head_id;
    logic [7:0]  head_priority;
  } rsp_t;

endpackage

FILE: rtl/ppq_cell.sv
// One slot of the sorted chain: holds an entry, shifts right on insert, rotates left on removal.
module ppq_cell import ppq_pkg::*; #(
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned PRIO_BITS = 8,
  parameter int unsigned CW        = 5,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic [CW-1:0]        count_i,
  input  logic [ID_BITS-1:0]   new_id_i,
  input  logic [PRIO_BITS-1:0] new_prio_i,
  input  logic [ID_BITS-1:0]   left_id_i,
  input  logic [PRIO_BITS-1:0] left_prio_i,
  input  logic                 left_gt_i,
  input  logic [ID_BITS-1:0]   right_id_i,
  input  logic [PRIO_BITS-1:0] right_prio_i,
  input  logic [ID_BITS-1:0]   head_id_i,
  input  logic [PRIO_BITS-1:0] head_prio_i,
  output logic [ID_BITS-1:0]   id_o,
  output logic [PRIO_BITS-1:0] prio_o,
  output logic                 gt_o
);

  localparam logic [CW:0] POS  = (CW+1)'(IDX);
  localparam logic [CW:0] POS1 = (CW+1)'(IDX + 1);

  logic [ID_BITS-1:0]   id_q, id_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic [CW:0]          cnt;
  logic                 below, at_cnt, before_tail, is_tail;

  assign cnt         = {1'b0, count_i};
  assign below       = POS < cnt;
  assign at_cnt      = POS == cnt;
  assign before_tail = POS1 < cnt;
  assign is_tail     = POS1 == cnt;
  assign gt_o        = below && (prio_q > new_prio_i);

  always_comb begin
    id_d   = id_q;
    prio_d = prio_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        if (left_gt_i) begin
          id_d   = left_id_i;
          prio_d = left_prio_i;
        end else if (gt_o || at_cnt) begin
          id_d   = new_id_i;
          prio_d = new_prio_i;
        end
      end
      CELL_ROTATE: begin
        if (before_tail) begin
          id_d   = right_id_i;
          prio_d = right_prio_i;
        end else if (is_tail && ctrl_i.kept) begin
          id_d   = head_id_i;
          prio_d = head_prio_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign id_o   = id_q;
  assign prio_o = prio_q;

endmodule

FILE: rtl/priority_process_queue.sv
// Top level of the priority process queue: command sequencer, cell chain and result register.
//
// A bounded queue of (id, priority) entries kept sorted by ascending priority number.
// Request channel in_valid_i / in_stall_o / in_req_i carries one command per beat:
// insert, run the head priority group, run a given priority, or clear. Every command
// returns exactly one beat on out_valid_o / out_stall_i / out_rsp_o with status,
// removed count, occupancy and the head entry after the command.
// Sequence: insert and clear pass from acceptance through the DONE state to the result
// register, and so do commands refused on an empty or full queue. A removal first
// rotates the whole chain through cell 0 one slot per cycle in the SCAN state, once
// per entry held, dropping matching entries. One command is worked on at a time;
// in_stall_o is low only while the sequencer is idle.
// The result sits in an output register; a stalled result holds its beat, and the
// next command may be accepted meanwhile. Its result waits until the register frees.
// Reset clears the occupancy and the handshake state; slot contents are not reset
// and are never shown before being written.
module priority_process_queue import ppq_pkg::*; #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  fsm_e                 state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        steps_q, steps_d;
  logic [CW-1:0]        removed_q, removed_d;
  status_e              status_q, status_d;
  cmd_e                 cmd_q, cmd_d;
  logic [PRIO_BITS-1:0] target_q, target_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_q, out_d;

  cell_ctrl_t           ctrl;
  logic [31:0]          id_ext, prio_ext;
  logic [ID_BITS-1:0]   new_id;
  logic [PRIO_BITS-1:0] new_prio;
  logic [ID_BITS-1:0]   ids   [DEPTH];
  logic [PRIO_BITS-1:0] prios [DEPTH];
  logic                 gts   [DEPTH];
  logic                 accept, out_free;
  logic [31:0]          cnt_ext, rem_ext, head_id_ext, head_prio_ext;

  assign id_ext   = {16'b0, in_req_i.proc_id};
  assign prio_ext = {24'b0, in_req_i.priority_req};
  assign new_id   = id_ext[ID_BITS-1:0];
  assign new_prio = prio_ext[PRIO_BITS-1:0];

  assign in_stall_o = state_q != FSM_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]   l_id, r_id;
    logic [PRIO_BITS-1:0] l_prio, r_prio;
    logic                 l_gt;
    if (i == 0) begin : g_first
      assign l_id   = '0;
      assign l_prio = '0;
      assign l_gt   = 1'b0;
    end else begin : g_mid
      assign l_id   = ids[i-1];
      assign l_prio = prios[i-1];
      assign l_gt   = gts[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_id   = ids[i];
      assign r_prio = prios[i];
    end else begin : g_inner
      assign r_id   = ids[i+1];
      assign r_prio = prios[i+1];
    end
    ppq_cell #(
      .ID_BITS  (ID_BITS),
      .PRIO_BITS(PRIO_BITS),
      .CW       (CW),
      .IDX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .new_id_i    (new_id),
      .new_prio_i  (new_prio),
      .left_id_i   (l_id),
      .left_prio_i (l_prio),
      .left_gt_i   (l_gt),
      .right_id_i  (r_id),
      .right_prio_i(r_prio),
      .head_id_i   (ids[0]),
      .head_prio_i (prios[0]),
      .id_o        (ids[i]),
      .prio_o      (prios[i]),
      .gt_o        (gts[i])
    );
  end

  assign cnt_ext       = 32'(count_q);
  assign rem_ext       = 32'(removed_q);
  assign head_id_ext   = 32'(ids[0]);
  assign head_prio_ext = 32'(prios[0]);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    steps_d     = steps_q;
    removed_d   = removed_q;
    status_d    = status_q;
    cmd_d       = cmd_q;
    target_d    = target_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ctrl.op     = CELL_HOLD;
    ctrl.kept   = 1'b1;

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          cmd_d     = in_req_i.cmd;
          removed_d = '0;
          status_d  = ST_OK;
          state_d   = FSM_DONE;
          unique case (in_req_i.cmd)
            CMD_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                ctrl.op = CELL_INSERT;
                count_d = count_q + CW'(1);
              end
            end
            CMD_RUN_HEAD, CMD_RUN_PRIO: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                target_d = (in_req_i.cmd == CMD_RUN_HEAD) ? prios[0] : new_prio;
                steps_d  = count_q;
                state_d  = FSM_SCAN;
              end
            end
            CMD_CLEAR: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                removed_d = count_q;
                count_d   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_SCAN: begin
        ctrl.op   = CELL_ROTATE;
        ctrl.kept = prios[0] != target_q;
        if (!ctrl.kept) begin
          count_d   = count_q - CW'(1);
          removed_d = removed_q + CW'(1);
        end
        steps_d = steps_q - CW'(1);
        if (steps_q == CW'(1)) begin
          state_d = FSM_DONE;
          if (cmd_q == CMD_RUN_PRIO && removed_d == '0) begin
            status_d = ST_NOT_FOUND;
          end
        end
      end
      FSM_DONE: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.status        = status_q;
          out_d.removed_count = rem_ext[4:0];
          out_d.occupancy     = cnt_ext[4:0];
          out_d.head_id       = (count_q != '0) ? head_id_ext[15:0] : 16'b0;
          out_d.head_priority = (count_q != '0) ? head_prio_ext[7:0] : 8'b0;
          state_d             = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q   <= steps_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    cmd_q     <= cmd_d;
    target_q  <= target_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: rtl/ppq_checker.sv
// Port-level checks for the priority process queue, bound to the top level.
module ppq_assert import ppq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_req_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result beat changed while stalled");

  a_full_no_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_FULL |->
      out_rsp_o.removed_count == 5'd0 && out_rsp_o.occupancy == 5'(DEPTH))
    else $error("full status with removal or wrong occupancy");

  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == ST_EMPTY |->
      out_rsp_o.removed_count == 5'd0 && out_rsp_o.occupancy == 5'd0 &&
      out_rsp_o.head_id == 16'd0 && out_rsp_o.head_priority == 8'd0)
    else $error("empty status with nonzero fields");

  // one command in flight: no new request taken in the cycle after one was taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while a command is in flight");

endmodule

bind priority_process_queue ppq_assert #(.DEPTH(DEPTH)) u_ppq_checker (.*);

FILE: tb/ppq_checker.sv
// Checker for the priority process queue: models the sorted queue and compares each response.
module ppq_checker import ppq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rsp_t        out_rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;

  logic [15:0] slot_id_q   [DEPTH];
  logic [7:0]  slot_prio_q [DEPTH];
  int unsigned held = 0;
  rsp_t        predicted_rsps [$];
  int unsigned fails = 0;
  int unsigned pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // Drop every entry of priority p, order of the rest kept.
  function automatic int unsigned drop_priority(input logic [7:0] p);
    int unsigned kept = 0;
    int unsigned removed;
    for (int unsigned k = 0; k < held; k++) begin
      if (slot_prio_q[k] != p) begin
        slot_id_q[kept]   = slot_id_q[k];
        slot_prio_q[kept] = slot_prio_q[k];
        kept++;
      end
    end
    removed = held - kept;
    held    = kept;
    return removed;
  endfunction

  function automatic rsp_t execute_cmd(input req_t r);
    rsp_t        rsp;
    status_e     st      = ST_OK;
    int unsigned removed = 0;
    int unsigned pos     = 0;
    case (r.cmd)
      CMD_INSERT: begin
        if (held >= DEPTH) begin
          st = ST_FULL;
        end else begin
          while (pos < held && slot_prio_q[pos] <= r.priority_req) pos++;
          for (int unsigned k = held; k > pos; k--) begin
            slot_id_q[k]   = slot_id_q[k-1];
            slot_prio_q[k] = slot_prio_q[k-1];
          end
          slot_id_q[pos]   = r.proc_id;
          slot_prio_q[pos] = r.priority_req;
          held++;
        end
      end
      CMD_RUN_HEAD: begin
        if (held == 0) st = ST_EMPTY;
        else removed = drop_priority(slot_prio_q[0]);
      end
      CMD_RUN_PRIO: begin
        if (held == 0) begin
          st = ST_EMPTY;
        end else begin
          removed = drop_priority(r.priority_req);
          if (removed == 0) st = ST_NOT_FOUND;
        end
      end
      default: begin
        if (held == 0) begin
          st = ST_EMPTY;
        end else begin
          removed = held;
          held    = 0;
        end
      end
    endcase
    rsp.status        = st;
    rsp.removed_count = 5'(removed);
    rsp.occupancy     = 5'(held);
    rsp.head_id       = (held != 0) ? slot_id_q[0] : '0;
    rsp.head_priority = (held != 0) ? slot_prio_q[0] : '0;
    return rsp;
  endfunction

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (predicted_rsps.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected beat st %0d rm %0d occ %0d id %h pr %h", $realtime,
                     out_rsp_i.status, out_rsp_i.removed_count, out_rsp_i.occupancy,
                     out_rsp_i.head_id, out_rsp_i.head_priority);
        end else begin
          exp_rsp = predicted_rsps.pop_front();
          if (out_rsp_i.status !== exp_rsp.status ||
              out_rsp_i.removed_count !== exp_rsp.removed_count ||
              out_rsp_i.occupancy !== exp_rsp.occupancy ||
              out_rsp_i.head_id !== exp_rsp.head_id ||
              out_rsp_i.head_priority !== exp_rsp.head_priority) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: mismatch exp st %0d rm %0d occ %0d id %h pr %h, got st %0d rm %0d occ %0d id %h pr %h",
                       $realtime, exp_rsp.status, exp_rsp.removed_count, exp_rsp.occupancy,
                       exp_rsp.head_id, exp_rsp.head_priority, out_rsp_i.status,
                       out_rsp_i.removed_count, out_rsp_i.occupancy, out_rsp_i.head_id,
                       out_rsp_i.head_priority);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predicted_rsps.push_back(execute_cmd(in_req_i));
      pending = predicted_rsps.size();
    end
  end

endmodule

FILE: tb/tb_priority_process_queue.sv
// Testbench top for the priority process queue: clock, reset, command stimulus and verdict.
module tb_priority_process_queue import ppq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  req_t        in_req    = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_rsp;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned gap_pct     = 14;
  int unsigned idle_cycles = 0;

  priority_process_queue #(
    .DEPTH    (DEPTH),
    .ID_BITS  (16),
    .PRIO_BITS(8)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  ppq_checker #(.DEPTH(DEPTH)) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) out_stall = ($urandom_range(99) < gap_pct);

  // Ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cmd(input cmd_e c, input logic [15:0] id, input logic [7:0] p);
    req_t r;
    r = '{cmd: c, proc_id: id, priority_req: p};
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req   = r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Mostly near a base so priority groups form; sometimes anywhere.
  function automatic logic [7:0] pick_priority(input logic [7:0] base);
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return base + 8'($urandom_range(5));
  endfunction

  initial begin
    int unsigned roll;
    int unsigned ins_pct;
    logic [7:0]  base;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty queue
    send_cmd(CMD_RUN_HEAD, 16'h0000, 8'h00);
    send_cmd(CMD_RUN_PRIO, 16'hFFFF, 8'hFF);
    send_cmd(CMD_CLEAR,    16'h0000, 8'h00);
    // priority extremes, equal priorities keep arrival order
    send_cmd(CMD_INSERT, 16'hFFFF, 8'h00);
    send_cmd(CMD_INSERT, 16'h0000, 8'hFF);
    send_cmd(CMD_INSERT, 16'h1234, 8'h00);
    send_cmd(CMD_RUN_PRIO, 16'h0000, 8'd77);
    // fill, then insert into a full queue
    repeat (13) send_cmd(CMD_INSERT, 16'($urandom), 8'($urandom_range(254, 1)));
    send_cmd(CMD_INSERT, 16'($urandom), 8'h00);
    send_cmd(CMD_RUN_PRIO, 16'h0000, 8'hFF);
    send_cmd(CMD_RUN_HEAD, 16'h0000, 8'h00);
    send_cmd(CMD_CLEAR,    16'h0000, 8'h00);

    for (int phase = 0; phase < 8; phase++) begin
      gap_pct = (phase == 4) ? 0 : 14;
      ins_pct = (phase % 2 == 1) ? 85 : 50;
      base    = 8'($urandom_range(255));
      for (int n = 0; n < 200; n++) begin
        roll = $urandom_range(99);
        if (roll < ins_pct)
          send_cmd(CMD_INSERT, 16'($urandom), pick_priority(base));
        else if (roll < 97 && $urandom_range(1) == 0)
          send_cmd(CMD_RUN_HEAD, 16'($urandom), 8'($urandom));
        else if (roll < 97)
          send_cmd(CMD_RUN_PRIO, 16'($urandom), pick_priority(base));
        else
          send_cmd(CMD_CLEAR, 16'($urandom), 8'($urandom));
      end
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DEPTH + 4) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
